>>> design/stmf_pkg.sv
// stmf_pkg: shared types and constants for the sliding trimmed-mean filter
// holds sample width, default window settings, item kinds, states and cell link types
// no dependencies
package stmf_pkg;

   // field widths
   localparam int SAMPLE_W = 12;
   localparam int TDATA_W  = 16;

   // default window settings
   localparam int DEF_WINDOW = 10;
   localparam int DEF_TRIM   = 2;

   // what an input item asks for
   typedef enum logic [0:0] {
      KIND_SAMPLE = 1'b0,
      KIND_CLEAR  = 1'b1
   } kind_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SUM,
      ST_MUL,
      ST_PUSH
   } state_type;

   // per-cycle command to every cell
   typedef struct packed {
      logic load;
      logic clear;
   } cell_ctrl_type;

   // link passed from one cell to the next, lower index to higher
   typedef struct packed {
      logic evicted;   // oldest entry sits at or below this cell
      logic fits;      // the compacted entry here is <= the new sample
   } link_type;

endpackage

>>> design/stmf_cell.sv
// stmf_cell: one slot of the sorted window, holding a value and its age
// evicts the oldest entry and inserts the new sample in sorted place in the same register update
// depends on stmf_pkg
module stmf_cell #(
   parameter int WINDOW = stmf_pkg::DEF_WINDOW,
   parameter int INDEX  = 0,
   localparam int AGE_W = $clog2(WINDOW)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  stmf_pkg::cell_ctrl_type       ctrl,
   input  logic [stmf_pkg::SAMPLE_W-1:0] sample,
   input  logic [stmf_pkg::SAMPLE_W-1:0] left_val,
   input  logic [AGE_W-1:0]              left_age,
   input  logic [stmf_pkg::SAMPLE_W-1:0] right_val,
   input  logic [AGE_W-1:0]              right_age,
   input  stmf_pkg::link_type            link_in,
   output stmf_pkg::link_type            link_out,
   output logic [stmf_pkg::SAMPLE_W-1:0] val,
   output logic [AGE_W-1:0]              age
);
   import stmf_pkg::*;

   localparam logic [AGE_W-1:0] LAST_AGE  = AGE_W'(WINDOW - 1);
   localparam logic [AGE_W-1:0] START_AGE = AGE_W'(INDEX);
   localparam bit               IS_LAST   = (INDEX == WINDOW - 1);

   logic [SAMPLE_W-1:0] val_ff, val_in;
   logic [AGE_W-1:0]    age_ff, age_in;
   logic                seen;
   logic                fits;
   logic [SAMPLE_W-1:0] here_val, prev_val;
   logic [AGE_W-1:0]    here_age, prev_age;

   // entry that lands here once the evicted one is squeezed out
   always_comb begin
      seen     = link_in.evicted | (age_ff == LAST_AGE);
      here_val = seen ? right_val : val_ff;
      here_age = seen ? right_age : age_ff;
      prev_val = link_in.evicted ? val_ff : left_val;
      prev_age = link_in.evicted ? age_ff : left_age;
      fits     = !IS_LAST && (here_val <= sample);
      link_out.evicted = seen;
      link_out.fits    = fits;
   end

   // next slot contents: compacted entry, new sample, or entry shifted up
   always_comb begin
      val_in = val_ff;
      age_in = age_ff;
      if (ctrl.clear) begin
         val_in = '0;
         age_in = START_AGE;
      end else if (ctrl.load) begin
         if (fits) begin
            val_in = here_val;
            age_in = here_age + AGE_W'(1);
         end else if (link_in.fits) begin
            val_in = sample;
            age_in = '0;
         end else begin
            val_in = prev_val;
            age_in = prev_age + AGE_W'(1);
         end
      end
   end

   // slot registers, zero history with distinct ages after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         val_ff <= '0;
         age_ff <= START_AGE;
      end else begin
         val_ff <= val_in;
         age_ff <= age_in;
      end
   end

   assign val = val_ff;
   assign age = age_ff;

endmodule

>>> design/sliding_trimmed_mean_filter.sv
// sliding_trimmed_mean_filter: trimmed mean of the last WINDOW samples
// a sample item is inserted into the cell row as it is accepted (insert and evict), then the
// adder sums the kept slots in ST_SUM, the reciprocal multiply scales the sum in ST_MUL and
// ST_PUSH loads the output register, stalling while an unaccepted result is still held there;
// no new item is accepted until then; a clear item zeroes the history without leaving idle
// and gives no output; reset (synchronous) zeroes the history, no clearing pass
module sliding_trimmed_mean_filter #(
   parameter int WINDOW = stmf_pkg::DEF_WINDOW,
   parameter int TRIM   = stmf_pkg::DEF_TRIM
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [stmf_pkg::TDATA_W-1:0] req_tdata,   // [11:0] sample
   input  logic [0:0]                   req_tuser,   // [0] kind
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [stmf_pkg::TDATA_W-1:0] rsp_tdata    // [11:0] filtered
);
   import stmf_pkg::*;

   localparam int AGE_W     = $clog2(WINDOW);
   localparam int IDX_W     = $clog2(WINDOW);
   localparam int KEEP      = WINDOW - 2 * TRIM;
   localparam int KEEP_SAFE = (KEEP > 0) ? KEEP : 1;
   localparam int LAST_KEPT = (KEEP > 0) ? (WINDOW - TRIM - 1) : 0;
   localparam int L_BITS    = $clog2(KEEP_SAFE);
   localparam int SUM_W     = SAMPLE_W + L_BITS;
   localparam int SHIFT     = SUM_W + L_BITS;
   localparam int MULT_W    = SUM_W + 1;
   localparam int PROD_W    = SUM_W + MULT_W;
   localparam longint unsigned MULT_FULL =
      ((64'd1 << SHIFT) + 64'(KEEP_SAFE) - 64'd1) / 64'(KEEP_SAFE);
   localparam logic [MULT_W-1:0] MULT = MULT_W'(MULT_FULL);

   state_type           state_ff, state_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [SUM_W-1:0]    acc_ff, acc_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0] rsp_data_ff, rsp_data_in;

   cell_ctrl_type       ctrl;
   logic [SAMPLE_W-1:0] sample;
   kind_type            kind;
   logic                req_take;

   logic [SAMPLE_W-1:0] cell_val [WINDOW];
   logic [AGE_W-1:0]    cell_age [WINDOW];
   logic [SAMPLE_W-1:0] pad_val  [WINDOW+2];
   logic [AGE_W-1:0]    pad_age  [WINDOW+2];
   link_type            link     [WINDOW+1];

   assign sample   = req_tdata[SAMPLE_W-1:0];
   assign kind     = kind_type'(req_tuser[0]);
   assign req_take = req_tvalid && req_tready;

   // neighbor view with zero padding at both ends of the row
   assign pad_val[0]        = '0;
   assign pad_age[0]        = '0;
   assign pad_val[WINDOW+1] = '0;
   assign pad_age[WINDOW+1] = '0;
   assign link[0].evicted   = 1'b0;
   assign link[0].fits      = 1'b1;

   // row of sorted cells, lowest value at index 0
   for (genvar g = 0; g < WINDOW; g++) begin : g_cell
      assign pad_val[g+1] = cell_val[g];
      assign pad_age[g+1] = cell_age[g];

      stmf_cell #(
         .WINDOW (WINDOW),
         .INDEX  (g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .sample    (sample),
         .left_val  (pad_val[g]),
         .left_age  (pad_age[g]),
         .right_val (pad_val[g+2]),
         .right_age (pad_age[g+2]),
         .link_in   (link[g]),
         .link_out  (link[g+1]),
         .val       (cell_val[g]),
         .age       (cell_age[g])
      );
   end

   // sequencer: clear or insert, sum the kept slots, scale by reciprocal, hand off
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      acc_in       = acc_ff;
      prod_in      = prod_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      ctrl.load    = 1'b0;
      ctrl.clear   = 1'b0;
      req_tready   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_take) begin
               if (kind == KIND_CLEAR) begin
                  ctrl.clear = 1'b1;
               end else begin
                  ctrl.load = 1'b1;
                  acc_in    = '0;
                  idx_in    = IDX_W'(TRIM);
                  state_in  = (KEEP > 0) ? ST_SUM : ST_MUL;
               end
            end
         end
         ST_SUM: begin
            acc_in = acc_ff + SUM_W'(cell_val[idx_ff]);
            idx_in = idx_ff + IDX_W'(1);
            if (idx_ff == IDX_W'(LAST_KEPT)) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = PROD_W'(acc_ff) * PROD_W'(MULT);
            state_in = ST_PUSH;
         end
         ST_PUSH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = prod_ff[SHIFT +: SAMPLE_W];
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      acc_ff      <= acc_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = TDATA_W'(rsp_data_ff);

`ifndef SYNTHESIS
   // some slot always holds the oldest entry
   a_oldest_present: assert property (@(posedge clock) disable iff (reset)
      link[WINDOW].evicted)
      else $error("no cell holds the oldest entry");

   // the first slot of the row never exceeds the last one
   a_row_sorted: assert property (@(posedge clock) disable iff (reset)
      cell_val[0] <= cell_val[WINDOW-1])
      else $error("cell row out of order");

   // a clear item leaves the highest slot of the history at zero
   a_clear_zeroes: assert property (@(posedge clock) disable iff (reset)
      (req_take && (kind == KIND_CLEAR)) |=> (cell_val[WINDOW-1] == '0))
      else $error("history not zero after clear");
`endif

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for sliding_trimmed_mean_filter, sample and clear items
// keeps its own ten-deep history and sort to predict every filtered item
// depends on stmf_pkg and sliding_trimmed_mean_filter
module tb_top;
   import stmf_pkg::*;

   localparam int WIN         = DEF_WINDOW;
   localparam int TRIM        = DEF_TRIM;
   localparam int KEEP        = WIN - 2 * TRIM;
   localparam int ITEM_CYCLES = KEEP + 3;
   localparam int TAIL_CYCLES = 4 * ITEM_CYCLES;
   localparam int STALL_LIMIT = 3000;
   localparam int HOLD_CYCLES = 300;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [TDATA_W-1:0]  req_tdata = '0;   // [11:0] sample
   logic [0:0]          req_tuser = '0;   // [0] kind
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [TDATA_W-1:0]  rsp_tdata;        // [11:0] filtered

   // bench state
   logic [SAMPLE_W-1:0] sample_window [WIN];
   logic [SAMPLE_W-1:0] expected_filtered [$];
   int                  error_count = 0;
   int                  samples_sent = 0;
   int                  clears_sent = 0;
   int                  results_checked = 0;
   int                  sender_idle_pct = 0;
   int                  receiver_stall_pct = 0;
   int                  quiet_cycles = 0;
   logic                rsp_hold = 1'b0;
   event                start_rsp_hold;

   sliding_trimmed_mean_filter #(
      .WINDOW (WIN),
      .TRIM   (TRIM)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // sort the held samples and average the middle ones
   function automatic logic [SAMPLE_W-1:0] trimmed_mean_of_window();
      logic [SAMPLE_W-1:0] sorted [WIN];
      logic [SAMPLE_W-1:0] v;
      int                  j;
      int unsigned         total;
      total = 0;
      if (KEEP <= 0) return '0;
      for (int i = 0; i < WIN; i++) sorted[i] = sample_window[i];
      for (int i = 1; i < WIN; i++) begin
         v = sorted[i];
         j = i - 1;
         while (j >= 0 && sorted[j] > v) begin
            sorted[j + 1] = sorted[j];
            j--;
         end
         sorted[j + 1] = v;
      end
      for (int i = TRIM; i < WIN - TRIM; i++) total += sorted[i];
      return SAMPLE_W'(total / KEEP);
   endfunction

   // update the predicted history for one accepted item
   task automatic predict_item(input kind_type kind, input logic [SAMPLE_W-1:0] sample);
      if (kind == KIND_CLEAR) begin
         for (int i = 0; i < WIN; i++) sample_window[i] = '0;
         clears_sent++;
      end else begin
         for (int i = WIN - 1; i > 0; i--) sample_window[i] = sample_window[i - 1];
         sample_window[0] = sample;
         expected_filtered.push_back(trimmed_mean_of_window());
         samples_sent++;
      end
   endtask

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= 30) $display("ERROR at %0t: %s", $realtime, what);
   endtask

   // offer one item, with a random gap first, and wait for acceptance
   task automatic send_item(input kind_type kind, input logic [SAMPLE_W-1:0] sample);
      int gap;
      gap = 0;
      while (gap < 40 && $urandom_range(99) < sender_idle_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(TDATA_W - SAMPLE_W){1'b0}}, sample};
      req_tuser  <= kind;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_item(kind, sample);
   endtask

   task automatic stop_sending();
      req_tvalid <= 1'b0;
   endtask

   // stop sending until every expected item is back, then let the bench idle for a tail
   task automatic wait_drained();
      stop_sending();
      @(posedge clock);
      while (expected_filtered.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   // random mix: full range, extremes, tiny and near-full values with many ties, some clear items
   task automatic run_random_items(input int count, input int send_pct, input int recv_pct);
      logic [SAMPLE_W-1:0] sample;
      kind_type            kind;
      sender_idle_pct    = send_pct;
      receiver_stall_pct = recv_pct;
      for (int n = 0; n < count; n++) begin
         kind = ($urandom_range(99) < 4) ? KIND_CLEAR : KIND_SAMPLE;
         case ($urandom_range(3))
            0: sample = SAMPLE_W'($urandom_range(4095));
            1: sample = $urandom_range(1) ? 12'hFFF : 12'h000;
            2: sample = SAMPLE_W'($urandom_range(7));
            default: sample = 12'hFFF - SAMPLE_W'($urandom_range(7));
         endcase
         if ($urandom_range(1)) sample = SAMPLE_W'($urandom_range(4095));
         send_item(kind, sample);
      end
      wait_drained();
   endtask

   // filling window, extremes, bit patterns, and clears whose samples are ignored
   task automatic test_directed_cases();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      send_item(KIND_SAMPLE, 12'h000);
      repeat (10) send_item(KIND_SAMPLE, 12'hFFF);
      send_item(KIND_CLEAR, 12'hFFF);
      send_item(KIND_SAMPLE, 12'h555);
      send_item(KIND_SAMPLE, 12'hAAA);
      send_item(KIND_SAMPLE, 12'hFFF);
      send_item(KIND_SAMPLE, 12'h001);
      send_item(KIND_SAMPLE, 12'h800);
      send_item(KIND_CLEAR, 12'h000);
      send_item(KIND_CLEAR, 12'hAAA);
      send_item(KIND_SAMPLE, 12'hFFF);
      send_item(KIND_SAMPLE, 12'h7FF);
      send_item(KIND_SAMPLE, 12'h000);
      wait_drained();
   endtask

   task automatic test_back_to_back();
      run_random_items(200, 0, 0);
   endtask

   task automatic test_sender_gaps();
      run_random_items(150, 78, 0);
   endtask

   task automatic test_receiver_stalls();
      run_random_items(150, 0, 78);
   endtask

   task automatic test_both_idle();
      run_random_items(200, 7, 7);
   endtask

   // long output hold while items keep coming, so the input backs up
   task automatic test_output_hold();
      -> start_rsp_hold;
      run_random_items(80, 0, 0);
   endtask

   // short bursts, each followed by a full drain
   task automatic test_drain_pause();
      for (int b = 0; b < 8; b++) run_random_items(12, 20, 20);
   endtask

   // output ready, random stalls unless a long hold is running
   always @(posedge clock) begin
      if (rsp_hold) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // long hold counted here
   always begin
      @(start_rsp_hold);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   // compare each output item with the oldest prediction
   always @(posedge clock) begin : check_results
      logic [SAMPLE_W-1:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_filtered.size() == 0) begin
            report_mismatch($sformatf("unexpected item, filtered %0d",
                                      rsp_tdata[SAMPLE_W-1:0]));
         end else begin
            want = expected_filtered.pop_front();
            results_checked++;
            if (rsp_tdata[SAMPLE_W-1:0] !== want)
               report_mismatch($sformatf("filtered got %0d expected %0d",
                                         rsp_tdata[SAMPLE_W-1:0], want));
         end
      end
   end

   // watchdog on cycles with no handshake on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout: %0d cycles without an item, %0d still expected",
                  quiet_cycles, expected_filtered.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < WIN; i++) sample_window[i] = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_back_to_back();
      test_sender_gaps();
      test_receiver_stalls();
      test_both_idle();
      test_output_hold();
      test_drain_pause();
      $display("summary: %0d samples and %0d clears sent, %0d filtered items checked",
               samples_sent, clears_sent, results_checked);
      $display("summary: filling window, extremes, ties, idle mixes, long hold, drains");
      if (error_count == 0 && expected_filtered.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

>>> files.f
design/stmf_pkg.sv
design/stmf_cell.sv
design/sliding_trimmed_mean_filter.sv
test/tb_top.sv
